// ===== src/rhc_pkg.sv =====
// ============================================================================
// rhc_pkg - shared definitions of the RGB to HSV converter
// Default widths, queue depth and the classification flags that travel
// from the front stage through the queue to the divider pipeline.
// ============================================================================
`default_nettype none

package rhc_pkg;

    localparam int CHANNEL_BITS_DEF  = 8;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    // Per-pixel classification made by the front stage.
    typedef struct packed {
        logic gray;      // min equals max: hue and saturation are zero
        logic hue_neg;   // hue numerator below zero, wrap the quotient
        logic sat_full;  // min is zero: saturation clamps to all ones
    } t_rhc_flags;

endpackage

`default_nettype wire

// ===== src/rhc_pixel_if.sv =====
// ============================================================================
// rhc_pixel_if - RGB pixel stream
// Valid/ready channel carrying one red, green and blue sample per beat.
// ============================================================================
`default_nettype none

interface rhc_pixel_if
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== src/rhc_hsv_if.sv =====
// ============================================================================
// rhc_hsv_if - HSV pixel stream
// Valid/ready channel carrying one hue, saturation and brightness per beat.
// ============================================================================
`default_nettype none

interface rhc_hsv_if
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic [FRACTION_BITS-1:0] hue;
    logic [FRACTION_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0]  brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

`default_nettype wire

// ===== src/rhc_front.sv =====
// ============================================================================
// rhc_front - pixel classification stage
// Find max, min and hue sector, and register the divider operands.
// ============================================================================
`default_nettype none

module rhc_front
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    localparam int DW = CHANNEL_BITS + 3
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    rhc_pixel_if.sink                    i_pix,
    output      logic                    o_valid,
    input  wire logic                    i_ready,
    output      t_rhc_flags              o_flags,
    output      logic [DW-1:0]           o_hue_num,
    output      logic [DW-1:0]           o_hue_den,
    output      logic [CHANNEL_BITS-1:0] o_sat_num,
    output      logic [CHANNEL_BITS-1:0] o_sat_den
);
    localparam int C = CHANNEL_BITS;

    logic [C-1:0]  hi, lo, delta;
    logic [C:0]    diff;
    logic [DW-1:0] base;
    logic [DW:0]   num;
    logic [DW:0]   num_abs;
    logic          accept;
    logic          r_valid;
    t_rhc_flags    n_flags;

    always_comb begin
        hi = i_pix.red;
        lo = i_pix.red;
        if (i_pix.green > hi) hi = i_pix.green;
        if (i_pix.blue  > hi) hi = i_pix.blue;
        if (i_pix.green < lo) lo = i_pix.green;
        if (i_pix.blue  < lo) lo = i_pix.blue;
        delta = hi - lo;

        // blue wins ties, then green, then red
        if (hi == i_pix.blue) begin
            base = {1'b0, delta, 2'b00};
            diff = {1'b0, i_pix.red} - {1'b0, i_pix.green};
        end else if (hi == i_pix.green) begin
            base = {2'b00, delta, 1'b0};
            diff = {1'b0, i_pix.blue} - {1'b0, i_pix.red};
        end else begin
            base = '0;
            diff = {1'b0, i_pix.green} - {1'b0, i_pix.blue};
        end

        num     = {1'b0, base} + {{3{diff[C]}}, diff};
        num_abs = num[DW] ? (~num + 1'b1) : num;

        n_flags.gray     = (hi == lo);
        n_flags.hue_neg  = num[DW];
        n_flags.sat_full = (lo == '0);
    end

    assign i_pix.ready = !r_valid || i_ready;
    assign accept      = i_pix.valid && i_pix.ready;
    assign o_valid     = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_flags   <= n_flags;
            o_hue_num <= num_abs[DW-1:0];
            o_hue_den <= {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
            o_sat_num <= delta;
            o_sat_den <= hi;
        end
    end

endmodule

`default_nettype wire

// ===== src/rhc_queue.sv =====
// ============================================================================
// rhc_queue - short decoupling queue
// Register-based FIFO between the classification stage and the dividers.
// ============================================================================
`default_nettype none

module rhc_queue
    import rhc_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output      logic             o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output      logic             o_valid,
    input  wire logic             i_ready,
    output      logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/rhc_back.sv =====
// ============================================================================
// rhc_back - divider pipeline
// Two restoring dividers, one quotient bit per stage, plus result fixup.
// ============================================================================
`default_nettype none

module rhc_back
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int DW = CHANNEL_BITS + 3
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output      logic                    o_ready,
    input  wire t_rhc_flags              i_flags,
    input  wire logic [DW-1:0]           i_hue_num,
    input  wire logic [DW-1:0]           i_hue_den,
    input  wire logic [CHANNEL_BITS-1:0] i_sat_num,
    input  wire logic [CHANNEL_BITS-1:0] i_sat_den,
    rhc_hsv_if.source                    o_hsv
);
    localparam int C = CHANNEL_BITS;
    localparam int F = FRACTION_BITS;

    logic          en;
    logic [F-1:0]  r_vld;
    t_rhc_flags    r_flg  [F];
    logic [DW-1:0] r_hrem [F];
    logic [DW-1:0] r_hden [F];
    logic [F-1:0]  r_hq   [F];
    logic [C-1:0]  r_srem [F];
    logic [C-1:0]  r_sden [F];
    logic [F-1:0]  r_sq   [F];

    // Advance the whole pipeline unless the output beat is stalled.
    assign en      = !r_vld[F-1] || o_hsv.ready;
    assign o_ready = en;

    for (genvar s = 0; s < F; s++) begin : g_stage
        logic          vld_in;
        t_rhc_flags    flg_in;
        logic [DW-1:0] hrem_in, hden_in;
        logic [F-1:0]  hq_in, sq_in;
        logic [C-1:0]  srem_in, sden_in;
        logic [DW:0]   h2, hsub;
        logic [C:0]    s2, ssub;
        logic          hge, sge;

        if (s == 0) begin : g_head
            assign vld_in  = i_valid;
            assign flg_in  = i_flags;
            assign hrem_in = i_hue_num;
            assign hden_in = i_hue_den;
            assign hq_in   = '0;
            assign srem_in = i_sat_num;
            assign sden_in = i_sat_den;
            assign sq_in   = '0;
        end else begin : g_link
            assign vld_in  = r_vld[s-1];
            assign flg_in  = r_flg[s-1];
            assign hrem_in = r_hrem[s-1];
            assign hden_in = r_hden[s-1];
            assign hq_in   = r_hq[s-1];
            assign srem_in = r_srem[s-1];
            assign sden_in = r_sden[s-1];
            assign sq_in   = r_sq[s-1];
        end

        assign h2   = {hrem_in, 1'b0};
        assign hge  = (h2 >= {1'b0, hden_in});
        assign hsub = h2 - {1'b0, hden_in};
        assign s2   = {srem_in, 1'b0};
        assign sge  = (s2 >= {1'b0, sden_in});
        assign ssub = s2 - {1'b0, sden_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_flg[s]  <= flg_in;
                r_hden[s] <= hden_in;
                r_hrem[s] <= hge ? hsub[DW-1:0] : h2[DW-1:0];
                r_hq[s]   <= {hq_in[F-2:0], hge};
                r_sden[s] <= sden_in;
                r_srem[s] <= sge ? ssub[C-1:0] : s2[C-1:0];
                r_sq[s]   <= {sq_in[F-2:0], sge};
            end
        end
    end

    always_comb begin
        o_hsv.valid      = r_vld[F-1];
        o_hsv.brightness = r_sden[F-1];
        if (r_flg[F-1].gray) begin
            o_hsv.hue        = '0;
            o_hsv.saturation = '0;
        end else begin
            // wrap a negative hue by one full turn; zero stays zero
            o_hsv.hue        = r_flg[F-1].hue_neg ? (~r_hq[F-1] + 1'b1) : r_hq[F-1];
            o_hsv.saturation = r_flg[F-1].sat_full ? '1 : r_sq[F-1];
        end
    end

endmodule

`default_nettype wire

// ===== src/rgb_to_hsv_converter.sv =====
// ============================================================================
// rgb_to_hsv_converter - RGB to HSV pixel converter
// Classify each pixel up front, queue it, then divide in a bit-per-stage
// pipeline to form hue and saturation; brightness is the largest channel.
// ============================================================================
//
//   Channel  Dir  Beat payload                         Handshake
//   i_pix    in   red, green, blue (CHANNEL_BITS each)  valid/ready
//   o_hsv    out  hue, saturation (FRACTION_BITS),      valid/ready
//                 brightness (CHANNEL_BITS)
//
// Throughput is one pixel per clock while o_hsv is not stalled. Pixels pass
// the front register, the queue, then one divider stage per quotient bit;
// each divider stage resolves one hue bit and one saturation bit with a
// compare and subtract.
// Reset is synchronous and clears only valid bits, queue pointers and the queue count.
// A stalled output freezes the divider pipeline; the queue and the front
// register keep taking pixels until they fill.
// ============================================================================
`default_nettype none

module rgb_to_hsv_converter
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rhc_pixel_if.sink i_pix,
    rhc_hsv_if.source o_hsv
);
    localparam int C  = CHANNEL_BITS;
    localparam int DW = CHANNEL_BITS + 3;
    localparam int QW = $bits(t_rhc_flags) + 2 * DW + 2 * C;

    // front stage to queue
    logic          f_valid, f_ready;
    t_rhc_flags    f_flags;
    logic [DW-1:0] f_hue_num, f_hue_den;
    logic [C-1:0]  f_sat_num, f_sat_den;

    // queue to divider pipeline
    logic          q_valid, b_ready;
    logic [QW-1:0] q_data;
    t_rhc_flags    q_flags;
    logic [DW-1:0] q_hue_num, q_hue_den;
    logic [C-1:0]  q_sat_num, q_sat_den;

    rhc_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_flags   (f_flags),
        .o_hue_num (f_hue_num),
        .o_hue_den (f_hue_den),
        .o_sat_num (f_sat_num),
        .o_sat_den (f_sat_den)
    );

    // Pack the classified beat into one queue word.
    rhc_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_flags, f_hue_num, f_hue_den, f_sat_num, f_sat_den}),
        .o_valid (q_valid),
        .i_ready (b_ready),
        .o_data  (q_data)
    );

    assign {q_flags, q_hue_num, q_hue_den, q_sat_num, q_sat_den} = q_data;

    rhc_back #(
        .CHANNEL_BITS  (CHANNEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_ready   (b_ready),
        .i_flags   (q_flags),
        .i_hue_num (q_hue_num),
        .i_hue_den (q_hue_den),
        .i_sat_num (q_sat_num),
        .i_sat_den (q_sat_den),
        .o_hsv     (o_hsv)
    );

    // A stalled output beat must freeze the dividers: no pop from the queue.
    a_stall_freezes_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.valid && !o_hsv.ready |-> !b_ready)
        else $error("divider pipeline advanced under a stalled output beat");

    // A classified beat the queue cannot take must stay in the front register.
    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid && !f_ready |=> f_valid)
        else $error("front beat dropped while the queue was full");

    // Black pixels carry zero hue and zero saturation.
    a_black_is_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.valid && (o_hsv.brightness == '0)
            |-> (o_hsv.hue == '0) && (o_hsv.saturation == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

`default_nettype wire
